### rtl/qdc_ebd_pkg.sv
`default_nettype none
package qdc_ebd_pkg;

  // Store and buffer geometry
  localparam int unsigned STORE_DEPTH  = 32;
  localparam int unsigned BUFFER_WORDS = 4096;
  localparam int unsigned MAX_RESULTS  = 32;

  localparam int unsigned SD_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned WP_W = $clog2(BUFFER_WORDS);
  localparam int unsigned CNT_W = 6;  // header count field, stored count, result count

  // Stored word layout: kind[20:18], channel[17:13], overflow[12], value[11:0]
  localparam int unsigned ENTRY_W = 21;

  // Word kinds, bits 26..24
  localparam logic [2:0] KIND_DATUM   = 3'd0;
  localparam logic [2:0] KIND_HEADER  = 3'd2;
  localparam logic [2:0] KIND_EOB     = 3'd4;
  localparam logic [2:0] KIND_INVALID = 3'd6;

  // Result status codes
  localparam logic [2:0] STAT_DATA       = 3'd0;
  localparam logic [2:0] STAT_UNEXP_HDR  = 3'd1;
  localparam logic [2:0] STAT_UNEXP_EOB  = 3'd2;
  localparam logic [2:0] STAT_INVALID    = 3'd3;
  localparam logic [2:0] STAT_BAD_STORED = 3'd4;
  localparam logic [2:0] STAT_SURPLUS    = 3'd5;

  // Configuration register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_MASK_LOW   = 3'd0;
  localparam logic [2:0] REG_MASK_HIGH  = 3'd1;
  localparam logic [2:0] REG_BOARD      = 3'd2;
  localparam logic [2:0] REG_SKIP_MODE  = 3'd3;
  localparam logic [2:0] REG_LIMIT      = 3'd4;

endpackage
`default_nettype wire

### rtl/qdc_event_block_decoder.sv
`default_nettype none
// Channel  | Direction | Handshake              | Payload
// in_      | input     | in_valid / in_stall    | in_raw_word[31:0]
// out_     | output    | out_valid / out_stall  | status, event_count, channel,
//          |           |                        | adc_value, overflow, last
// cfg_     | input     | APB psel/penable/pready| 64-bit registers at 8 * index
//
// Header, datum, reserved and buffer-end words are taken in idle. An error
// word goes through S_ERR, which waits out any output stall. An end-of-block
// word walks the stored words newest first through one registered store read
// port, S_WALK_RD then S_WALK_EV per word, and S_END flushes the held datum.
// Synchronous active-low reset clears control state, not the walk registers
// or the word store. in_stall is high whenever the sequencer is away from
// idle; the output register decouples out_stall from the input side.
module qdc_event_block_decoder
  import qdc_ebd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_raw_word,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [23:0]      out_event_count,
  output logic [6:0]       out_channel,
  output logic [11:0]      out_adc_value,
  output logic             out_overflow,
  output logic             out_last,

  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [5:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);

  // Sequencer codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_WALK_RD = 3'd1;  // store read issued
  localparam logic [2:0] S_WALK_EV = 3'd2;  // evaluate stored word
  localparam logic [2:0] S_END     = 3'd3;  // flush held datum
  localparam logic [2:0] S_ERR     = 3'd4;  // send error result

  localparam logic [WP_W-1:0] WP_LAST = WP_W'(BUFFER_WORDS - 1);
  localparam logic [SD_W-1:0] PTR_TOP = SD_W'(STORE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STORE_DEPTH);
  localparam logic [CNT_W-1:0] MAXR_C  = CNT_W'(MAX_RESULTS);

  // Configuration registers
  logic [63:0] mask_low_r;
  logic [31:0] mask_high_r;
  logic [1:0]  board_r;
  logic        skip_mode_r;
  logic [30:0] limit_r;

  // Parse state
  logic [2:0]       state_r, state_nxt;
  logic             in_block_r, in_block_nxt;
  logic [CNT_W-1:0] exp_cnt_r, exp_cnt_nxt;
  logic [CNT_W-1:0] str_cnt_r, str_cnt_nxt;
  logic [SD_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic             halted_r, halted_nxt;
  logic [WP_W-1:0]  word_pos_r, word_pos_nxt;
  logic [31:0]      blk_cnt_r, blk_cnt_nxt;

  // Walk state
  logic [SD_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [23:0]      ev_r, ev_nxt;
  logic             send_r, send_nxt;
  logic [CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic [2:0]       err_r, err_nxt;
  logic             clr_after_r, clr_after_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [6:0]       pend_chan_r, pend_chan_nxt;
  logic [11:0]      pend_val_r, pend_val_nxt;
  logic             pend_ov_r, pend_ov_nxt;

  // Word store
  logic [ENTRY_W-1:0] store_mem [STORE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_wdata;

  // Output register
  logic        out_valid_r;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [23:0] out_ev_r, out_ev_nxt;
  logic [6:0]  out_chan_r, out_chan_nxt;
  logic [11:0] out_val_r, out_val_nxt;
  logic        out_ov_r, out_ov_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_load;
  logic        out_free;

  // Decode helpers
  logic        in_acc;
  logic [2:0]  kind;
  logic        buf_end;
  logic [6:0]  walk_chan;
  logic [127:0] mask_all;
  logic        chan_en;
  logic        want;
  logic        cfg_wr;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign kind     = in_raw_word[26:24];
  assign buf_end  = (word_pos_r == WP_LAST);
  assign out_free = !out_valid_r || !out_stall;

  assign mask_all  = {32'd0, mask_high_r, mask_low_r};
  assign walk_chan = {board_r, rd_data_r[17:13]};
  assign chan_en   = mask_all[walk_chan];
  assign want      = send_r && chan_en && (res_cnt_r < MAXR_C);

  always_comb begin
    state_nxt      = state_r;
    in_block_nxt   = in_block_r;
    exp_cnt_nxt    = exp_cnt_r;
    str_cnt_nxt    = str_cnt_r;
    wr_ptr_nxt     = wr_ptr_r;
    halted_nxt     = halted_r;
    word_pos_nxt   = word_pos_r;
    blk_cnt_nxt    = blk_cnt_r;
    rd_ptr_nxt     = rd_ptr_r;
    rem_nxt        = rem_r;
    ev_nxt         = ev_r;
    send_nxt       = send_r;
    res_cnt_nxt    = res_cnt_r;
    err_nxt        = err_r;
    clr_after_nxt  = clr_after_r;
    pend_valid_nxt = pend_valid_r;
    pend_chan_nxt  = pend_chan_r;
    pend_val_nxt   = pend_val_r;
    pend_ov_nxt    = pend_ov_r;
    mem_we         = 1'b0;
    mem_wdata      = {kind, in_raw_word[20:16], in_raw_word[12:0]};
    out_load       = 1'b0;
    out_status_nxt = STAT_DATA;
    out_ev_nxt     = ev_r;
    out_chan_nxt   = pend_chan_r;
    out_val_nxt    = pend_val_r;
    out_ov_nxt     = pend_ov_r;
    out_last_nxt   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_raw_word == 32'hFFFF_FFFF) begin
            in_block_nxt = 1'b0;
            exp_cnt_nxt  = '0;
            str_cnt_nxt  = '0;
            halted_nxt   = 1'b0;
            word_pos_nxt = '0;
          end else begin
            clr_after_nxt = buf_end;
            if (!halted_r) begin
              if (in_block_r && (str_cnt_r < exp_cnt_r)) begin
                mem_we      = 1'b1;
                str_cnt_nxt = str_cnt_r + CNT_W'(1);
                wr_ptr_nxt  = (wr_ptr_r == PTR_TOP) ? '0 : wr_ptr_r + SD_W'(1);
              end else if (kind == KIND_HEADER) begin
                if (!in_block_r) begin
                  exp_cnt_nxt  = in_raw_word[13:8];
                  str_cnt_nxt  = '0;
                  wr_ptr_nxt   = '0;
                  in_block_nxt = 1'b1;
                end else begin
                  err_nxt   = STAT_UNEXP_HDR;
                  ev_nxt    = '0;
                  state_nxt = S_ERR;
                end
              end else if (kind == KIND_EOB) begin
                if (in_block_r) begin
                  // Launch the walk from the newest stored word
                  in_block_nxt   = 1'b0;
                  ev_nxt         = in_raw_word[23:0];
                  rem_nxt        = (str_cnt_r > DEPTH_C) ? DEPTH_C : str_cnt_r;
                  rd_ptr_nxt     = (wr_ptr_r == '0) ? PTR_TOP : wr_ptr_r - SD_W'(1);
                  send_nxt       = skip_mode_r || (blk_cnt_r < {1'b0, limit_r});
                  res_cnt_nxt    = '0;
                  pend_valid_nxt = 1'b0;
                  state_nxt      = S_WALK_RD;
                end else begin
                  err_nxt   = STAT_UNEXP_EOB;
                  ev_nxt    = '0;
                  state_nxt = S_ERR;
                end
              end else if (kind == KIND_INVALID) begin
                if (!skip_mode_r) begin
                  err_nxt   = STAT_INVALID;
                  ev_nxt    = '0;
                  state_nxt = S_ERR;
                end
              end else if (kind == KIND_DATUM) begin
                err_nxt   = STAT_SURPLUS;
                ev_nxt    = '0;
                state_nxt = S_ERR;
              end
            end
            if (buf_end) begin
              in_block_nxt = 1'b0;
              exp_cnt_nxt  = '0;
              str_cnt_nxt  = '0;
              halted_nxt   = 1'b0;
              word_pos_nxt = '0;
            end else begin
              word_pos_nxt = word_pos_r + WP_W'(1);
            end
          end
        end
      end

      S_WALK_RD: begin
        if (rem_r == '0) begin
          err_nxt   = STAT_SURPLUS;
          state_nxt = S_END;
        end else begin
          state_nxt = S_WALK_EV;
        end
      end

      S_WALK_EV: begin
        if (rd_data_r[20:18] != KIND_DATUM) begin
          err_nxt   = STAT_BAD_STORED;
          state_nxt = S_END;
        end else if (!(want && pend_valid_r && !out_free)) begin
          if (want) begin
            // Held datum goes out once an older one proves it is not last
            out_load       = pend_valid_r;
            pend_valid_nxt = 1'b1;
            pend_chan_nxt  = walk_chan;
            pend_val_nxt   = rd_data_r[11:0];
            pend_ov_nxt    = rd_data_r[12];
            res_cnt_nxt    = res_cnt_r + CNT_W'(1);
          end
          if (rd_data_r[17:13] == 5'd0) begin
            err_nxt   = STAT_DATA;
            state_nxt = S_END;
          end else begin
            rem_nxt    = rem_r - CNT_W'(1);
            rd_ptr_nxt = (rd_ptr_r == '0) ? PTR_TOP : rd_ptr_r - SD_W'(1);
            state_nxt  = S_WALK_RD;
          end
        end
      end

      S_END: begin
        if (err_r == STAT_DATA) begin
          if (!pend_valid_r) begin
            blk_cnt_nxt = blk_cnt_r + 32'd1;
            state_nxt   = S_IDLE;
          end else if (out_free) begin
            out_load       = 1'b1;
            out_last_nxt   = 1'b1;
            pend_valid_nxt = 1'b0;
            blk_cnt_nxt    = blk_cnt_r + 32'd1;
            state_nxt      = S_IDLE;
          end
        end else if (pend_valid_r && (res_cnt_r == MAXR_C)) begin
          // No slot left: the error takes the last data slot
          pend_valid_nxt = 1'b0;
          state_nxt      = S_ERR;
        end else if (!pend_valid_r) begin
          state_nxt = S_ERR;
        end else if (out_free) begin
          out_load       = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_ERR;
        end
      end

      S_ERR: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = err_r;
          out_chan_nxt   = '0;
          out_val_nxt    = '0;
          out_ov_nxt     = 1'b0;
          out_last_nxt   = 1'b1;
          halted_nxt     = !clr_after_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_block_r   <= 1'b0;
      exp_cnt_r    <= '0;
      str_cnt_r    <= '0;
      wr_ptr_r     <= '0;
      halted_r     <= 1'b0;
      word_pos_r   <= '0;
      blk_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_block_r   <= in_block_nxt;
      exp_cnt_r    <= exp_cnt_nxt;
      str_cnt_r    <= str_cnt_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      halted_r     <= halted_nxt;
      word_pos_r   <= word_pos_nxt;
      blk_cnt_r    <= blk_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Walk and output payload
  always_ff @(posedge clk) begin
    rd_ptr_r    <= rd_ptr_nxt;
    rem_r       <= rem_nxt;
    ev_r        <= ev_nxt;
    send_r      <= send_nxt;
    res_cnt_r   <= res_cnt_nxt;
    err_r       <= err_nxt;
    clr_after_r <= clr_after_nxt;
    pend_chan_r <= pend_chan_nxt;
    pend_val_r  <= pend_val_nxt;
    pend_ov_r   <= pend_ov_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_ev_r     <= out_ev_nxt;
      out_chan_r   <= out_chan_nxt;
      out_val_r    <= out_val_nxt;
      out_ov_r     <= out_ov_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // Word store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[wr_ptr_r] <= mem_wdata;
    end
    rd_data_r <= store_mem[rd_ptr_r];
  end

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_low_r  <= '0;
      mask_high_r <= '0;
      board_r     <= '0;
      skip_mode_r <= 1'b0;
      limit_r     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[5:3])
        REG_MASK_LOW:  mask_low_r  <= cfg_pwdata;
        REG_MASK_HIGH: mask_high_r <= cfg_pwdata[31:0];
        REG_BOARD:     board_r     <= cfg_pwdata[1:0];
        REG_SKIP_MODE: skip_mode_r <= cfg_pwdata[0];
        REG_LIMIT:     limit_r     <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[5:3])
      REG_MASK_LOW:  cfg_prdata = mask_low_r;
      REG_MASK_HIGH: cfg_prdata = {32'd0, mask_high_r};
      REG_BOARD:     cfg_prdata = {62'd0, board_r};
      REG_SKIP_MODE: cfg_prdata = {63'd0, skip_mode_r};
      REG_LIMIT:     cfg_prdata = {33'd0, limit_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_event_count = out_ev_r;
  assign out_channel     = out_chan_r;
  assign out_adc_value   = out_val_r;
  assign out_overflow    = out_ov_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

### test/tb_qdc_event_block_decoder.sv
`timescale 1ns / 1ps
module tb_qdc_event_block_decoder;
  import qdc_ebd_pkg::*;

  localparam int CLK_HALF_NS   = 5;
  localparam int TIMEOUT_NS    = 5_000_000;
  // Longest silent walk, with margin: read and evaluate per word plus block close.
  localparam int SETTLE_CYCLES = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 20_000;
  localparam int PRINT_LIMIT   = 200;

  // One decoded result as it leaves the block
  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] event_count;
    logic [6:0]  channel;
    logic [11:0] adc_value;
    logic        overflow;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_raw_word = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [23:0] out_event_count;
  logic [6:0]  out_channel;
  logic [11:0] out_adc_value;
  logic        out_overflow;
  logic        out_last;

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [5:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  qdc_event_block_decoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_word    (in_raw_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_event_count(out_event_count),
    .out_channel    (out_channel),
    .out_adc_value  (out_adc_value),
    .out_overflow   (out_overflow),
    .out_last       (out_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  always begin
    #CLK_HALF_NS clk = 1'b1;
    #CLK_HALF_NS clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Decoder shadow: register copies and parse state, updated per accepted word
  // ---------------------------------------------------------------------------
  logic [63:0] en_low = '0;       // channel enables 0..63
  logic [31:0] en_high = '0;      // channel enables 64..95
  logic [1:0]  board_sel = '0;
  logic        skip_bad = 1'b0;   // skip not-valid words, no block limit
  logic [30:0] block_quota = '0;  // block limit

  logic        blk_open = 1'b0;
  logic [5:0]  blk_len = '0;      // words promised by the header
  int unsigned blk_fill = 0;      // words stored so far in this block
  logic [20:0] blk_words [STORE_DEPTH];
  logic        parse_stopped = 1'b0;
  int unsigned buf_pos = 0;
  logic [31:0] blocks_done = '0;

  result_t     decoded_results[$];

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;

  // Long receiver hold-off, requested by toggling hold_req
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  function automatic void reset_parse();
    blk_open = 1'b0;
    blk_len = '0;
    blk_fill = 0;
    parse_stopped = 1'b0;
    buf_pos = 0;
  endfunction

  function automatic bit channel_on(input logic [6:0] chan);
    if (chan < 64) return en_low[chan];
    if (chan < 96) return en_high[chan - 64];
    return 1'b0;  // board three lands above the mask
  endfunction

  function automatic result_t mk_result(input logic [2:0] status, input logic [23:0] ev,
                                        input logic [6:0] chan, input logic [11:0] val,
                                        input logic ov);
    result_t r;
    r.status = status;
    r.event_count = ev;
    r.channel = chan;
    r.adc_value = val;
    r.overflow = ov;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic result_t halt_with(input logic [2:0] code);
    parse_stopped = 1'b1;
    return mk_result(code, '0, '0, '0, 1'b0);
  endfunction

  // Work out the results one accepted word causes and queue them
  task automatic decode_word(input logic [31:0] word);
    result_t     burst[$];
    logic [2:0]  kind;
    logic [2:0]  fault;
    logic [20:0] entry;
    logic [23:0] ev;
    logic [6:0]  chan;
    int unsigned k;
    int unsigned floor_idx;
    bit          hit_zero;
    bit          may_send;

    kind = word[26:24];
    if (word == 32'hFFFF_FFFF) begin
      reset_parse();
      return;
    end
    if (!parse_stopped) begin
      if (blk_open && blk_fill < blk_len) begin
        // stored as is, checked only during the walk
        blk_words[blk_fill % STORE_DEPTH] = {kind, word[20:16], word[12:0]};
        blk_fill++;
      end else if (kind == KIND_HEADER) begin
        if (!blk_open) begin
          blk_len = word[13:8];
          blk_fill = 0;
          blk_open = 1'b1;
        end else begin
          burst.push_back(halt_with(STAT_UNEXP_HDR));
        end
      end else if (kind == KIND_EOB) begin
        if (blk_open) begin
          blk_open = 1'b0;
          ev = word[23:0];
          fault = STAT_DATA;
          hit_zero = 1'b0;
          may_send = skip_bad || (blocks_done < {1'b0, block_quota});
          floor_idx = (blk_fill > STORE_DEPTH) ? blk_fill - STORE_DEPTH : 0;
          k = blk_fill;
          // newest first, stop after channel 0
          while (k > floor_idx) begin
            k--;
            entry = blk_words[k % STORE_DEPTH];
            if (entry[20:18] != KIND_DATUM) begin
              fault = STAT_BAD_STORED;
              break;
            end
            chan = {board_sel, 5'b0} + entry[17:13];
            if (may_send && channel_on(chan) && burst.size() < MAX_RESULTS)
              burst.push_back(mk_result(STAT_DATA, ev, chan, entry[11:0], entry[12]));
            if (entry[17:13] == 5'd0) begin
              hit_zero = 1'b1;
              break;
            end
          end
          if (fault == STAT_DATA && !hit_zero) fault = STAT_SURPLUS;
          if (fault != STAT_DATA) begin
            parse_stopped = 1'b1;
            // error takes the last slot when the burst is full
            if (burst.size() == MAX_RESULTS) void'(burst.pop_back());
            burst.push_back(mk_result(fault, ev, '0, '0, 1'b0));
          end else begin
            blocks_done++;
          end
        end else begin
          burst.push_back(halt_with(STAT_UNEXP_EOB));
        end
      end else if (kind == KIND_INVALID) begin
        if (!skip_bad) burst.push_back(halt_with(STAT_INVALID));
      end else if (kind == KIND_DATUM) begin
        burst.push_back(halt_with(STAT_SURPLUS));
      end
    end
    buf_pos++;
    if (buf_pos >= BUFFER_WORDS) reset_parse();
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) decoded_results.push_back(burst[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and field-by-field comparison
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    // keep the log bounded if the block goes badly wrong
    if (mismatches <= PRINT_LIMIT)
      $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (decoded_results.size() == 0) begin
        report_mismatch("result with none pending, status", out_status, '0);
      end else begin
        want = decoded_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_event_count !== want.event_count)
          report_mismatch("event_count", out_event_count, want.event_count);
        if (out_channel !== want.channel)
          report_mismatch("channel", out_channel, want.channel);
        if (out_adc_value !== want.adc_value)
          report_mismatch("adc_value", out_adc_value, want.adc_value);
        if (out_overflow !== want.overflow)
          report_mismatch("overflow", out_overflow, want.overflow);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: one word per transfer, random gaps ahead of each
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_word(word);
    words_sent++;
  endtask

  // random word of a given kind; callers fill in the fields they care about
  function automatic logic [31:0] raw_of(input logic [2:0] kind);
    logic [31:0] w;
    w = $urandom;
    w[26:24] = kind;
    return w;
  endfunction

  task automatic send_header(input logic [5:0] n);
    logic [31:0] w;
    w = raw_of(KIND_HEADER);
    w[13:8] = n;
    send_word(w);
  endtask

  task automatic send_datum(input logic [4:0] ch, input logic [11:0] val, input logic ov);
    logic [31:0] w;
    w = raw_of(KIND_DATUM);
    w[20:16] = ch;
    w[12] = ov;
    w[11:0] = val;
    send_word(w);
  endtask

  task automatic send_eob(input logic [23:0] ev);
    logic [31:0] w;
    w = raw_of(KIND_EOB);
    w[23:0] = ev;
    send_word(w);
  endtask

  // Header, n stored words, end of block. zero_at picks the channel-0 word
  // (negative: none); bad_pct is the chance of a non-datum stored word.
  task automatic send_block(input int n, input int zero_at, input int bad_pct);
    send_header(n[5:0]);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < bad_pct)
        send_word(raw_of($urandom_range(1, 7)));
      else
        send_datum((i == zero_at) ? 5'd0 : 5'($urandom_range(1, 31)),
                   12'($urandom), 1'($urandom));
    end
    send_eob(24'($urandom));
  endtask

  // Lower valid, let every pending result out, then let a silent walk finish
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_MASK_LOW:  en_low = value;
      REG_MASK_HIGH: en_high = value[31:0];
      REG_BOARD:     board_sel = value[1:0];
      REG_SKIP_MODE: skip_bad = value[0];
      REG_LIMIT:     block_quota = value[30:0];
      default: ;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [63:0] ml, input logic [31:0] mh,
                           input logic [1:0] bd, input logic sk, input logic [30:0] lim);
    wait_until_idle();
    write_reg(REG_MASK_LOW, ml);
    write_reg(REG_MASK_HIGH, {32'h0, mh});
    write_reg(REG_BOARD, {62'h0, bd});
    write_reg(REG_SKIP_MODE, {63'h0, sk});
    write_reg(REG_LIMIT, {33'h0, lim});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Clean block, field extremes: value and overflow at both ends, top event count
  task automatic test_basic_block();
    configure('1, '1, 2'd0, 1'b0, 31'h7FFF_FFFF);
    send_header(6'd2);
    send_datum(5'd31, 12'hFFF, 1'b1);
    send_datum(5'd0, 12'h000, 1'b0);
    send_eob(24'hFF_FFFF);
    send_block(1, 0, 0);
  endtask

  // Each error kind; an all-ones word restarts parsing after each one
  task automatic test_error_words();
    logic [31:0] w;
    send_eob(24'h00_0000);                 // end of block outside a block
    send_word(32'hFFFF_FFFF);
    send_header(6'd0);                     // empty block
    send_eob(24'h12_3456);
    send_word(32'h0000_0000);              // datum outside a block, ignored while halted
    send_word(raw_of(KIND_HEADER));        // ignored while halted
    send_word(32'hFFFF_FFFF);
    send_word(raw_of(KIND_INVALID));       // not-valid word, halt mode
    send_word(32'hFFFF_FFFF);
    for (int k = 1; k < 8; k += 2) begin   // reserved kinds are skipped
      w = raw_of(3'(k));
      if (w == 32'hFFFF_FFFF) w[31] = 1'b0;
      send_word(w);
    end
    send_header(6'd0);
    send_header(6'd5);                     // second header where end is due
    send_word(32'hFFFF_FFFF);
    send_block(2, 0, 100);                 // stored words that are not data
    send_word(32'hFFFF_FFFF);
    send_block(2, -1, 0);                  // no channel-0 word
    send_word(32'hFFFF_FFFF);
  endtask

  task automatic test_skip_and_limit();
    configure('1, '1, 2'd1, 1'b1, 31'd0);
    send_word(raw_of(KIND_INVALID));       // skipped
    send_block(3, 2, 0);                   // limit ignored in skip mode
    configure('1, '1, 2'd1, 1'b0, 31'd0);
    send_block(2, 1, 0);                   // limit zero: nothing sent
    configure('1, '1, 2'd0, 1'b0, blocks_done[30:0] + 31'd1);
    send_block(2, 1, 0);                   // one block under the limit
    send_block(2, 1, 0);                   // now at the limit
  endtask

  task automatic test_board_and_mask();
    configure(64'h0, 32'h8000_0001, 2'd2, 1'b1, 31'h7FFF_FFFF);
    send_header(6'd3);
    send_datum(5'd0, 12'h5A5, 1'b0);       // channel 64
    send_datum(5'd5, 12'h111, 1'b1);       // channel 69, masked
    send_datum(5'd31, 12'hA5A, 1'b1);      // channel 95
    send_eob(24'h00_0001);
    configure('1, '1, 2'd3, 1'b1, 31'h7FFF_FFFF);
    send_block(4, 0, 0);                   // board three: all disabled
    configure(64'hFFFF_FFFF_0000_0000, 32'h0, 2'd1, 1'b0, 31'h7FFF_FFFF);
    send_block(4, 0, 0);
  endtask

  // More words than the store holds, and more data than result slots
  task automatic test_long_blocks();
    configure('1, '1, 2'd0, 1'b1, 31'h7FFF_FFFF);
    send_block(40, -1, 0);                 // full burst, error takes the last slot
    send_word(32'hFFFF_FFFF);
    send_block(34, 0, 0);                  // channel-0 word pushed out of the store
    send_word(32'hFFFF_FFFF);
    send_block(34, 5, 0);
    send_block(63, 62, 0);
  endtask

  // Buffer ends on its word count, in the middle of a block
  task automatic test_buffer_wrap();
    logic [31:0] w;
    int          saved_idle;
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    send_word(32'hFFFF_FFFF);
    while (buf_pos < BUFFER_WORDS - 2) begin
      w = $urandom;
      w[24] = 1'b1;                        // odd kinds are reserved
      if (w == 32'hFFFF_FFFF) w[31] = 1'b0;
      send_word(w);
    end
    send_header(6'd3);
    send_datum(5'd0, 12'h123, 1'b0);       // last word of the buffer
    send_datum(5'd1, 12'h456, 1'b1);       // new buffer: surplus datum
    send_word(32'hFFFF_FFFF);
    send_idle_pct = saved_idle;
  endtask

  // Receiver holds off while blocks keep coming, so the block backs up
  task automatic test_output_backpressure();
    configure('1, '1, 2'd0, 1'b1, 31'h7FFF_FFFF);
    hold_req <= ~hold_req;
    for (int b = 0; b < 4; b++) send_block(8, 0, 0);
    wait_until_idle();
  endtask

  task automatic pick_random_setup();
    logic [63:0] ml;
    logic [31:0] mh;
    logic [30:0] lim;
    int          r;
    r = $urandom_range(99);
    ml = (r < 15) ? 64'h0 : (r < 50) ? '1 : {$urandom, $urandom};
    r = $urandom_range(99);
    mh = (r < 15) ? 32'h0 : (r < 50) ? '1 : $urandom;
    r = $urandom_range(99);
    lim = (r < 20) ? 31'd0 : (r < 50) ? blocks_done[30:0] + 31'($urandom_range(0, 4))
                                      : 31'h7FFF_FFFF;
    configure(ml, mh, 2'($urandom_range(0, 2)), 1'($urandom), lim);
  endtask

  // Mostly well-formed blocks with random content; the rest broken blocks and noise
  task automatic run_traffic(input int idle_pct, input int stall_pct);
    int unsigned w0;
    int unsigned r0;
    int unsigned cfg_mark;
    int          r;
    int          n;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    w0 = words_sent;
    r0 = results_seen;
    cfg_mark = words_sent;
    pick_random_setup();
    while ((words_sent - w0 < 50 || results_seen - r0 < 25) && words_sent - w0 < 300) begin
      if (words_sent - cfg_mark >= 25) begin
        pick_random_setup();
        cfg_mark = words_sent;
      end
      r = $urandom_range(99);
      n = ($urandom_range(99) < 8) ? $urandom_range(33, 63) : $urandom_range(1, 8);
      if (parse_stopped && $urandom_range(99) < 80) begin
        send_word(32'hFFFF_FFFF);
      end else if (r < 65) begin
        r = $urandom_range(99);
        send_block(n, (r < 85) ? 0 : (r < 95) ? $urandom_range(0, n - 1) : -1, 2);
      end else if (r < 70) begin
        send_header(6'd0);
        send_eob(24'($urandom));
      end else if (r < 76) begin
        send_header(n[5:0]);               // one datum too many
        for (int i = 0; i <= n; i++) send_datum(5'($urandom), 12'($urandom), 1'($urandom));
      end else if (r < 90) begin
        send_word($urandom);
      end else if (r < 95) begin
        send_word(raw_of(KIND_INVALID));
      end else begin
        send_word(32'hFFFF_FFFF);
      end
    end
    wait_until_idle();
  endtask

  initial begin
    int guard;
    send_idle_pct = 26;
    recv_stall_pct = 55;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_block();
    test_error_words();
    test_skip_and_limit();
    test_board_and_mask();
    test_long_blocks();
    test_buffer_wrap();
    test_output_backpressure();
    run_traffic(26, 55);
    run_traffic(55, 26);
    run_traffic(0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (decoded_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (decoded_results.size() != 0)
      report_mismatch("results never produced", decoded_results.size(), '0);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### filelist.f
rtl/qdc_ebd_pkg.sv
rtl/qdc_event_block_decoder.sv
test/tb_qdc_event_block_decoder.sv
